// ===== rtl/core/cpse_pkg.sv =====
// cpse_pkg: types, codes and helpers for the CA PMT service extractor.
// Used by ca_pmt_service_extractor and its checker; no dependencies.
package cpse_pkg;

  localparam int MAX_ES_PIDS = 4;
  localparam int NUM_CA_IDS  = 4;

  localparam logic [11:0] POS_MAX       = 12'hFFF;
  localparam logic [11:0] MIN_MSG_BYTES = 12'd14;

  // Fixed byte positions in the message header
  localparam logic [11:0] POS_LENGTH    = 12'd3;
  localparam logic [11:0] POS_PROG_HI   = 12'd5;
  localparam logic [11:0] POS_PROG_LO   = 12'd6;
  localparam logic [11:0] POS_PIL_HI    = 12'd8;
  localparam logic [11:0] POS_PIL_LO    = 12'd9;
  localparam logic [11:0] POS_LOOP_BASE = 12'd10;
  localparam logic [11:0] POS_FIRST_DESC = 12'd11;

  // Offsets inside a CA descriptor
  localparam logic [11:0] DESC_LEN    = 12'd1;
  localparam logic [11:0] DESC_CA_HI  = 12'd2;
  localparam logic [11:0] DESC_CA_LO  = 12'd3;
  localparam logic [11:0] DESC_PID_HI = 12'd4;
  localparam logic [11:0] DESC_PID_LO = 12'd5;
  localparam logic [7:0]  DESC_MIN_LEN = 8'd4;

  // Offsets inside an ES entry header
  localparam logic [11:0] ES_PID_HI  = 12'd1;
  localparam logic [11:0] ES_PID_LO  = 12'd2;
  localparam logic [11:0] ES_INFO_HI = 12'd3;
  localparam logic [11:0] ES_INFO_LO = 12'd4;
  localparam logic [13:0] ES_DESC_OFS = 14'd6;
  localparam logic [13:0] ES_HDR_LEN  = 14'd5;

  typedef enum logic [2:0] {
    REG_NETWORK_ID  = 3'd0,
    REG_CA_ID_COUNT = 3'd1,
    REG_CA_ID_A     = 3'd2,
    REG_CA_ID_B     = 3'd3,
    REG_CA_ID_C     = 3'd4,
    REG_CA_ID_D     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] service_network_id;
    logic [15:0] program_number;
    logic [15:0] matched_ca_id;
    logic [12:0] ecm_pid;
    logic [2:0]  pid_count;
    logic [12:0] pid_first;
    logic [12:0] pid_second;
    logic [12:0] pid_third;
    logic [12:0] pid_fourth;
  } out_item_t;

  function automatic logic [11:0] sat_pos(input logic [13:0] v);
    sat_pos = (v > 14'(POS_MAX)) ? POS_MAX : v[11:0];
  endfunction

endpackage

// ===== rtl/core/ca_pmt_service_extractor.sv =====
// ca_pmt_service_extractor: byte-serial CA PMT parser producing one service record
// per message. Depends on cpse_pkg.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) carries one message byte per
//    transaction, byte 0 first; last_byte marks the final byte of the message.
//  - Output channel (out_valid_o/out_ready_i/out_data_o) carries one service record
//    per message, valid in the cycle after the transaction that carried last_byte.
//  - Config channel (cfg_valid_i/cfg_ready_o, always ready) writes network id, CA id
//    count and four CA ids; the user writes only while idle, unenforced by the block.
//  - Throughput: one byte per cycle when not stalled. Each byte updates the parse
//    registers in the same cycle it is taken (header fields, loop bounds, descriptor
//    match against the four ids in parallel), so bytes may follow back to back.
//  - Stall: the record sits in the output register; the block keeps taking bytes
//    as long as that register is empty or being drained this cycle, and stops
//    while a finished record waits on a stalled receiver.
//  - Reset: clears config registers, parse state save kept PIDs, and out_valid;
//    no clearing pass, the block takes bytes from the first cycle after reset.
module ca_pmt_service_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpse_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpse_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import cpse_pkg::*;

  // Config registers
  logic [15:0] net_id_q;
  logic [2:0]  ca_cnt_q;
  logic [15:0] ca_id_q [NUM_CA_IDS];

  // Parse state
  logic [11:0] pos_q, pos_d;
  logic [7:0]  sec_len_q, sec_len_d;
  logic [15:0] prog_q, prog_d;
  logic [11:0] pil_q, pil_d;          // program info length
  logic [11:0] ees_q, ees_d;          // start of next ES entry
  logic [11:0] eil_q, eil_d;          // ES info length
  logic [11:0] ds_q, ds_d;            // start of next descriptor
  logic [7:0]  dl_q, dl_d;            // descriptor length
  logic [15:0] pf_q, pf_d;            // partial field
  logic [4:0]  php_q, php_d;          // ECM PID high bits
  logic [15:0] found_q, found_d;
  logic [12:0] ecm_q, ecm_d;
  logic [2:0]  kpc_q, kpc_d;
  logic [12:0] kept_q [MAX_ES_PIDS];
  logic [12:0] kept_d [MAX_ES_PIDS];

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // Combinational helpers
  logic        in_fire;
  logic        do_parse;
  logic        in_prog;
  logic        in_desc;
  logic        desc_active;
  logic [11:0] desc_off;
  logic [11:0] es_off;
  logic [12:0] prog_end;
  logic [11:0] sec_end;
  logic [11:0] pos_nxt;
  logic [2:0]  id_lim;
  logic        ca_match;
  logic [7:0]  b;
  logic [11:0] pil_new;
  logic [11:0] eil_new;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    b           = in_data_i.data_byte;
    sec_end     = {4'd0, sec_len_q} + 12'd4;
    do_parse    = pos_q < sec_end;
    prog_end    = {1'b0, pil_q} + {1'b0, POS_LOOP_BASE};
    in_prog     = {1'b0, pos_q} < prog_end;
    in_desc     = in_prog || (pos_q < ees_q);
    desc_active = pos_q >= ds_q;
    desc_off    = pos_q - ds_q;
    es_off      = pos_q - ees_q;
    pos_nxt     = sat_pos(14'(pos_q) + 14'd1);
    pil_new     = {pil_q[11:8], b};
    eil_new     = {eil_q[11:8], b};

    // Only the first ca_id_count ids take part, capped at the number held
    id_lim   = (ca_cnt_q > 3'(NUM_CA_IDS)) ? 3'(NUM_CA_IDS) : ca_cnt_q;
    ca_match = 1'b0;
    for (int j = 0; j < NUM_CA_IDS; j++) begin
      if ((3'(j) < id_lim) && (ca_id_q[j] == pf_q)) begin
        ca_match = 1'b1;
      end
    end

    pos_d     = pos_q;
    sec_len_d = sec_len_q;
    prog_d    = prog_q;
    pil_d     = pil_q;
    ees_d     = ees_q;
    eil_d     = eil_q;
    ds_d      = ds_q;
    dl_d      = dl_q;
    pf_d      = pf_q;
    php_d     = php_q;
    found_d   = found_q;
    ecm_d     = ecm_q;
    kpc_d     = kpc_q;
    for (int i = 0; i < MAX_ES_PIDS; i++) begin
      kept_d[i] = kept_q[i];
    end
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (in_fire) begin
      if (do_parse) begin
        if (pos_q == POS_LENGTH) begin
          sec_len_d = b;
        end else if (pos_q == POS_PROG_HI) begin
          prog_d = {b, 8'd0};
        end else if (pos_q == POS_PROG_LO) begin
          prog_d = {prog_q[15:8], b};
        end else if (pos_q == POS_PIL_HI) begin
          pil_d = {b[3:0], 8'd0};
        end else if (pos_q == POS_PIL_LO) begin
          pil_d = pil_new;
          ds_d  = POS_FIRST_DESC;
          ees_d = sat_pos(14'(POS_LOOP_BASE) + 14'(pil_new));
        end else if (pos_q >= POS_LOOP_BASE) begin
          if (in_desc) begin
            // CA descriptor, program level or inside an ES entry
            if (desc_active) begin
              case (desc_off)
                DESC_LEN: begin
                  dl_d = b;
                  if (b < DESC_MIN_LEN) begin
                    ds_d = sat_pos(14'(ds_q) + 14'(b) + 14'd2);
                  end
                end
                DESC_CA_HI:  pf_d  = {b, 8'd0};
                DESC_CA_LO:  pf_d  = {pf_q[15:8], b};
                DESC_PID_HI: php_d = b[4:0];
                DESC_PID_LO: begin
                  if (ca_match) begin
                    found_d = pf_q;
                    ecm_d   = {php_q, b};
                  end
                  ds_d = sat_pos(14'(ds_q) + 14'(dl_q) + 14'd2);
                end
                default: ;
              endcase
            end
          end else begin
            // ES entry header
            case (es_off)
              ES_PID_HI: pf_d = {8'd0, b};
              ES_PID_LO: begin
                if (kpc_q < 3'(MAX_ES_PIDS)) begin
                  kept_d[kpc_q[1:0]] = {pf_q[4:0], b};
                  kpc_d = kpc_q + 3'd1;
                end
              end
              ES_INFO_HI: eil_d = {b[3:0], 8'd0};
              ES_INFO_LO: begin
                eil_d = eil_new;
                ds_d  = sat_pos(14'(ees_q) + ES_DESC_OFS);
                ees_d = sat_pos(14'(ees_q) + 14'(eil_new) + ES_HDR_LEN);
              end
              default: ;
            endcase
          end
        end
      end
      pos_d = pos_nxt;

      if (in_data_i.last_byte) begin
        // Record reflects this byte's updates; then restart for the next message
        out_valid_d                   = 1'b1;
        out_data_d.accepted           = (kpc_d != 3'd0) && (found_d != 16'd0) &&
                                        (pos_nxt >= MIN_MSG_BYTES) &&
                                        (pos_nxt >= {4'd0, sec_len_d} + 12'd4);
        out_data_d.service_network_id = net_id_q;
        out_data_d.program_number     = prog_d;
        out_data_d.matched_ca_id      = found_d;
        out_data_d.ecm_pid            = ecm_d;
        out_data_d.pid_count          = kpc_d;
        out_data_d.pid_first          = (kpc_d > 3'd0) ? kept_d[0] : 13'd0;
        out_data_d.pid_second         = (kpc_d > 3'd1) ? kept_d[1] : 13'd0;
        out_data_d.pid_third          = (kpc_d > 3'd2) ? kept_d[2] : 13'd0;
        out_data_d.pid_fourth         = (kpc_d > 3'd3) ? kept_d[3] : 13'd0;

        pos_d     = '0;
        sec_len_d = '0;
        prog_d    = '0;
        pil_d     = '0;
        ees_d     = '0;
        eil_d     = '0;
        ds_d      = '0;
        dl_d      = '0;
        pf_d      = '0;
        php_d     = '0;
        found_d   = '0;
        ecm_d     = '0;
        kpc_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sec_len_q   <= '0;
      prog_q      <= '0;
      pil_q       <= '0;
      ees_q       <= '0;
      eil_q       <= '0;
      ds_q        <= '0;
      dl_q        <= '0;
      pf_q        <= '0;
      php_q       <= '0;
      found_q     <= '0;
      ecm_q       <= '0;
      kpc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sec_len_q   <= sec_len_d;
      prog_q      <= prog_d;
      pil_q       <= pil_d;
      ees_q       <= ees_d;
      eil_q       <= eil_d;
      ds_q        <= ds_d;
      dl_q        <= dl_d;
      pf_q        <= pf_d;
      php_q       <= php_d;
      found_q     <= found_d;
      ecm_q       <= ecm_d;
      kpc_q       <= kpc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: kept PIDs are only read below the kept count
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ES_PIDS; i++) begin
      kept_q[i] <= kept_d[i];
    end
    out_data_q <= out_data_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_id_q <= '0;
      ca_cnt_q <= '0;
      for (int i = 0; i < NUM_CA_IDS; i++) begin
        ca_id_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NETWORK_ID:  net_id_q   <= cfg_data_i;
        REG_CA_ID_COUNT: ca_cnt_q   <= cfg_data_i[2:0];
        REG_CA_ID_A:     ca_id_q[0] <= cfg_data_i;
        REG_CA_ID_B:     ca_id_q[1] <= cfg_data_i;
        REG_CA_ID_C:     ca_id_q[2] <= cfg_data_i;
        REG_CA_ID_D:     ca_id_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/cpse_checker.sv =====
// cpse_checker: port-level assertions for ca_pmt_service_extractor, bound to it.
// Depends on cpse_pkg.
module cpse_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cpse_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cpse_pkg::out_item_t out_data_o
);
  import cpse_pkg::*;

  // A stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled record changed");

  // Bytes are always taken while no record is waiting
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // The last byte of a message yields a record in the next cycle
  a_last_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_byte |=> out_valid_o)
    else $error("no record after last byte");

  // An accepted service has a PID and a CA system
  a_accept_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |->
      (out_data_o.pid_count != 3'd0) && (out_data_o.matched_ca_id != 16'd0))
    else $error("accepted record without PID or CA system");

  // An unused fourth PID slot reads zero
  a_pid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.pid_count < 3'd4) |-> out_data_o.pid_fourth == 13'd0)
    else $error("unused PID slot not zero");

endmodule

bind ca_pmt_service_extractor cpse_checker u_cpse_checker (.*);
